FILE: sv/nearest_free_slot_below_unit_assert.svh
// Assertion macros for the nearest free slot allocator.
// Depends on nothing; included by the files that check their own logic.
`ifndef NEAREST_FREE_SLOT_BELOW_UNIT_ASSERT_SVH
`define NEAREST_FREE_SLOT_BELOW_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NFSB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NFSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NFSB_ASSERT_SAME(label, clk, rst, ante, cons)
`define NFSB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/nfsb_pkg.sv
// Types and constants shared by the nearest free slot allocator.
// Depends on nothing; used by the interfaces, the scan unit and the top level.
`timescale 1ns / 1ps
package nfsb_pkg;
   localparam int VALUE_W  = 10;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;
   localparam int MAX_SLOTS = 1024;

   typedef enum logic [STATUS_W-1:0] {
      ST_OWN     = 3'd0,
      ST_LOWER   = 3'd1,
      ST_DROPPED = 3'd2,
      ST_FULL    = 3'd3,
      ST_RANGE   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } scan_result_type;
endpackage

FILE: sv/nfsb_if.sv
// Handshake interfaces for the request and response channels of the allocator.
// Depends on nfsb_pkg for the field widths.
`timescale 1ns / 1ps
interface nfsb_req_if;
   import nfsb_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last_entry;
   modport source (output valid, output value, output last_entry, input ready);
   modport sink (input valid, input value, input last_entry, output ready);
endinterface

interface nfsb_rsp_if;
   import nfsb_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  slot;
   logic                now_full;
   logic                end_of_list;
   modport source (output valid, output status, output slot, output now_full,
                   output end_of_list, input ready);
   modport sink (input valid, input status, input slot, input now_full,
                 input end_of_list, output ready);
endinterface

FILE: sv/nfsb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module nfsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/nfsb_scan.sv
// Word scan unit: finds the highest free slot at or below a bit limit in one map word.
// Depends on nfsb_pkg.
`timescale 1ns / 1ps
module nfsb_scan (
   input  logic [nfsb_pkg::WORD_W-1:0] word_data,
   input  logic                        word_valid,
   input  logic [nfsb_pkg::BIT_W-1:0]  limit,
   output nfsb_pkg::scan_result_type   result
);
   import nfsb_pkg::*;

   logic [WORD_W-1:0] free_bits;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] cand;

   always_comb begin
      free_bits = word_valid ? ~word_data : {WORD_W{1'b1}};
      mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - limit);
      cand = free_bits & mask;
      result.found = |cand;
      result.pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (cand[i]) begin
            result.pos = BIT_W'(i);
         end
      end
   end
endmodule

FILE: sv/nearest_free_slot_below_unit.sv
// Sequence: a request for a full table or an out-of-range value goes from idle straight to
// the done state; any other request enters the scan state, which checks one 32-bit map word
// at a time downward, up to WORD_COUNT words (32 by default), before the done state loads the
// response register. The next request is taken only once the response register is loaded.
// Reset: synchronous, clears the control state, the count and the per-word valid bits,
// and sets max_value to 1023. There is no clearing pass.
`timescale 1ns / 1ps
`include "nearest_free_slot_below_unit_assert.svh"
module nearest_free_slot_below_unit #(
   parameter int SLOT_COUNT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   nfsb_req_if.sink                     req_chan,
   nfsb_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [nfsb_pkg::VALUE_W-1:0] csr_wr_data
);
   import nfsb_pkg::*;

   localparam int EFF_SLOTS  = (SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : SLOT_COUNT;
   localparam int WORD_COUNT = (EFF_SLOTS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [VALUE_W-1:0] EFF_TOP = VALUE_W'(EFF_SLOTS - 1);

   state_type             state_ff, state_in;
   logic [VALUE_W-1:0]    max_value_ff, max_value_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [WORD_COUNT-1:0] valid_ff, valid_in;
   logic [WORD_AW-1:0]    word_ff, word_in;
   logic [BIT_W-1:0]      limit_ff, limit_in;
   logic                  first_ff, first_in;
   logic                  last_ff, last_in;
   status_type            status_ff, status_in;
   logic [VALUE_W-1:0]    slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]    top;
   logic                  table_full;
   logic                  req_fire;
   logic                  out_load;
   logic                  rd_en;
   logic [WORD_AW-1:0]    rd_addr;
   logic                  wr_en;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     word_bits;
   scan_result_type       scan;

   nfsb_ram #(
      .WIDTH(WORD_W),
      .DEPTH(WORD_COUNT)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(word_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   nfsb_scan u_scan (
      .word_data (rd_data),
      .word_valid(valid_ff[word_ff]),
      .limit     (limit_ff),
      .result    (scan)
   );

   assign top = (max_value_ff > EFF_TOP) ? EFF_TOP : max_value_ff;
   assign table_full = count_ff > COUNT_W'(top);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign word_bits = valid_ff[word_ff] ? rd_data : '0;
   assign wr_data = word_bits | (WORD_W'(1) << scan.pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_value_ff <= VALUE_W'(MAX_SLOTS - 1);
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_value_ff <= max_value_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      limit_ff      <= limit_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      max_value_in  = max_value_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      word_in       = word_ff;
      limit_in      = limit_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = WORD_AW'(req_chan.value[VALUE_W-1:BIT_W]);
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               max_value_in = csr_wr_data;
               count_in = '0;
               valid_in = '0;
            end
            if (req_fire) begin
               last_in = req_chan.last_entry;
               slot_in = '0;
               word_in = WORD_AW'(req_chan.value[VALUE_W-1:BIT_W]);
               limit_in = req_chan.value[BIT_W-1:0];
               first_in = 1'b1;
               if (table_full) begin
                  status_in = ST_FULL;
                  state_in = S_DONE;
               end else if (req_chan.value > top) begin
                  status_in = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  rd_en = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_addr = word_ff - WORD_AW'(1);
            if (scan.found) begin
               wr_en = 1'b1;
               valid_in[word_ff] = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               slot_in = VALUE_W'({word_ff, scan.pos});
               status_in = (first_ff && (scan.pos == limit_ff)) ? ST_OWN : ST_LOWER;
               state_in = S_DONE;
            end else if (word_ff == '0) begin
               status_in = ST_DROPPED;
               state_in = S_DONE;
            end else begin
               rd_en = 1'b1;
               word_in = word_ff - WORD_AW'(1);
               limit_in = BIT_W'(WORD_W - 1);
               first_in = 1'b0;
            end
         end
         S_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in = slot_ff;
               rsp_full_in = table_full;
               rsp_last_in = last_ff;
               if (last_ff) begin
                  count_in = '0;
                  valid_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.now_full    = rsp_full_ff;
   assign rsp_chan.end_of_list = rsp_last_ff;

   `NFSB_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(top) + COUNT_W'(1))
   `NFSB_ASSERT_SAME(a_write_in_scan, clock, reset, wr_en, state_ff == S_SCAN)
   `NFSB_ASSERT_NEXT(a_found_done, clock, reset, (state_ff == S_SCAN) && scan.found,
                     state_ff == S_DONE)
   `NFSB_ASSERT_NEXT(a_last_clears, clock, reset, out_load && last_ff, count_ff == '0)
endmodule
